// ----- hdl/iqbal_pkg.sv -----
// Shared constants, word types and interface structs of the I/Q balance trainer.
package iqbal_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAX_BLOCK = 65536;
  localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
  localparam int COEF_W    = 32;
  localparam int STEP_W    = 16;
  localparam int FRAC_W    = 30;
  localparam int DISP_SH   = 16;

  // corrected sample and its Q15 view
  localparam int ZW        = SAMPLE_W + 3;
  localparam int SH_L      = (SAMPLE_W <= 16) ? 16 - SAMPLE_W : 0;
  localparam int SH_R      = (SAMPLE_W > 16) ? SAMPLE_W - 16 : 0;
  localparam int RW        = ZW + SH_L - SH_R;
  localparam int PRD_W     = 2 * RW;
  localparam int MP_W      = PRD_W + 1 + STEP_W + 1;
  localparam int D_W       = MP_W - 16;

  // block accumulators
  localparam int SUM_W     = COEF_W + CNT_W - 1;
  localparam int SQT_W     = 2 * COEF_W - FRAC_W;
  localparam int SQS_W     = SQT_W + CNT_W - 1;

  // shared divider
  localparam int DIV_NW    = SQS_W;
  localparam int DIV_DW    = COEF_W;
  localparam int DIV_CW    = $clog2(DIV_NW);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       block_end;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
    logic signed [COEF_W-1:0]   coef_re;
    logic signed [COEF_W-1:0]   coef_im;
    logic signed [COEF_W-1:0]   mean_re;
    logic signed [COEF_W-1:0]   mean_im;
    logic        [COEF_W-1:0]   var_re;
    logic        [COEF_W-1:0]   var_im;
    logic signed [COEF_W-1:0]   disp_re;
    logic signed [COEF_W-1:0]   disp_im;
    logic                       stats_valid;
  } out_t;

  // queued sample, tagged with the block end decision
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic [STEP_W-1:0]        step;
    logic signed [COEF_W-1:0] start_re;
    logic signed [COEF_W-1:0] start_im;
    logic                     train;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

// ----- hdl/iqbal_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module iqbal_div import iqbal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diffv;
  logic              fit;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_r, num_r[DIV_NW-1]};
    diffv = trial - {1'b0, den_r};
    fit   = trial >= {1'b0, den_r};
  end

  // shift quotient bits into the dividend register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[DIV_NW-2:0], fit};
        rem_r <= fit ? diffv[DIV_DW-1:0] : trial[DIV_DW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{busy: busy_r, done: done_r, quo: num_r, rem: rem_r};

endmodule

// ----- hdl/iqbal_front.sv -----
// Input side: accepts sample words, marks block ends and queues them.
module iqbal_front import iqbal_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output item_t q_item,
  output logic  q_valid,
  input  logic  q_pop
);

  item_t            ent_r [2];
  logic [1:0]       fill_r;
  logic             wp_r;
  logic             rp_r;
  logic [CNT_W-1:0] blk_r;
  logic             push;
  logic             pop;
  logic             last;

  assign in_ready = fill_r != 2'd2;
  assign q_valid  = fill_r != 2'd0;
  assign q_item   = ent_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  // end the block on request or when it reaches its maximum length
  assign last     = in_data.block_end || (blk_r == CNT_W'(MAX_BLOCK - 1));

  // track pointers, fill and block position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      blk_r  <= '0;
    end else begin
      if (push) begin
        wp_r  <= ~wp_r;
        blk_r <= last ? '0 : blk_r + 1'b1;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // store the tagged word
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= '{sample_i: in_data.sample_i, sample_q: in_data.sample_q, last: last};
    end
  end

endmodule

// ----- hdl/iqbal_back.sv -----
// Back end: correction, LMS update, block sums, statistics and output register.
module iqbal_back import iqbal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  item_t    q_item,
  input  logic     q_valid,
  output logic     q_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  localparam int PW = COEF_W + SAMPLE_W + 1;
  localparam logic [COEF_W-1:0] C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] C_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_PROD, S_SQR, S_MU, S_UPD, S_ABS2, S_ACC,
    S_MEAN_GO, S_MEAN_W, S_SQ_GO, S_SQ_W, S_MSQ, S_VAR,
    S_DISP_GO, S_DISP_W, S_EMIT
  } state_t;

  typedef struct packed {
    logic [COEF_W-1:0] mean;
    logic [COEF_W-1:0] var_v;
    logic [COEF_W-1:0] disp;
  } st_t;

  function automatic logic [COEF_W-1:0] sat_w(input logic signed [D_W:0] v);
    logic ok;
    ok = (&v[D_W:COEF_W-1]) | ~(|v[D_W:COEF_W-1]);
    if (ok) return v[COEF_W-1:0];
    return v[D_W] ? C_MIN : C_MAX;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_s(input logic signed [ZW-1:0] v);
    logic ok;
    ok = (&v[ZW-1:SAMPLE_W-1]) | ~(|v[ZW-1:SAMPLE_W-1]);
    if (ok) return v[SAMPLE_W-1:0];
    return v[ZW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

  state_t                    state_r;
  item_t                     item_r;
  logic signed [COEF_W-1:0]  coef_re_r, coef_im_r;
  logic signed [ZW-1:0]      z_re_r, z_im_r;
  logic signed [PRD_W-1:0]   rr_r, qq_r, rq_r;
  logic signed [D_W-1:0]     d_re_r, d_im_r;
  logic [SQT_W-1:0]          t_re_r, t_im_r;
  logic signed [SUM_W-1:0]   sum_re_r, sum_im_r;
  logic [SQS_W-1:0]          sq_re_r, sq_im_r;
  logic [CNT_W-1:0]          n_r;
  logic                      comp_r;
  logic [COEF_W-1:0]         m_abs_r;
  logic                      m_neg_r;
  logic [COEF_W:0]           q2_r, msq_r;
  logic [COEF_W-1:0]         v_r;
  st_t                       st_r [2];
  logic                      out_valid_r;
  out_t                      out_data_r;

  logic signed [PW-1:0]        p_re, p_im;
  logic signed [ZW-1:0]        z_re_nxt, z_im_nxt;
  logic signed [ZW+SH_L-1:0]   zl_re, zl_im;
  logic signed [RW-1:0]        r_re, r_im;
  logic signed [PRD_W:0]       diff, twice;
  logic signed [STEP_W:0]      mu_s;
  logic signed [MP_W-1:0]      mp_re, mp_im;
  logic [COEF_W-1:0]           w_re_nxt, w_im_nxt;
  logic [COEF_W-1:0]           ar, ai;
  logic [2*COEF_W-1:0]         sqa, sqi;
  logic signed [SUM_W-1:0]     sum_sel;
  logic                        neg_sel;
  logic [SUM_W-1:0]            sabs;
  logic [COEF_W-1:0]           m_abs_nxt, mean_nxt;
  logic [2*COEF_W-1:0]         mm;
  logic signed [COEF_W+1:0]    vd;
  logic [COEF_W-1:0]           v_nxt, disp_nxt;
  logic                        stats_go;

  // per-item datapath
  always_comb begin
    p_re     = coef_re_r * item_r.sample_i + coef_im_r * item_r.sample_q;
    p_im     = coef_im_r * item_r.sample_i - coef_re_r * item_r.sample_q;
    z_re_nxt = ZW'(item_r.sample_i) + ZW'(p_re >>> FRAC_W);
    z_im_nxt = ZW'(item_r.sample_q) + ZW'(p_im >>> FRAC_W);
    zl_re    = (ZW + SH_L)'(z_re_r) <<< SH_L;
    zl_im    = (ZW + SH_L)'(z_im_r) <<< SH_L;
    r_re     = RW'(zl_re >>> SH_R);
    r_im     = RW'(zl_im >>> SH_R);
    diff     = (PRD_W + 1)'(rr_r) - (PRD_W + 1)'(qq_r);
    twice    = (PRD_W + 1)'(rq_r) <<< 1;
    mu_s     = $signed({1'b0, cfg.step});
    mp_re    = mu_s * diff;
    mp_im    = mu_s * twice;
    w_re_nxt = sat_w((D_W + 1)'(coef_re_r) - (D_W + 1)'(d_re_r));
    w_im_nxt = sat_w((D_W + 1)'(coef_im_r) - (D_W + 1)'(d_im_r));
    ar       = coef_re_r[COEF_W-1] ? COEF_W'(-coef_re_r) : COEF_W'(coef_re_r);
    ai       = coef_im_r[COEF_W-1] ? COEF_W'(-coef_im_r) : COEF_W'(coef_im_r);
    sqa      = ar * ar;
    sqi      = ai * ai;
  end

  // statistics datapath, one component at a time
  always_comb begin
    sum_sel   = comp_r ? sum_im_r : sum_re_r;
    neg_sel   = sum_sel[SUM_W-1];
    sabs      = neg_sel ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    m_abs_nxt = COEF_W'(div_rsp.quo) + COEF_W'(neg_sel && (div_rsp.rem != '0));
    mean_nxt  = neg_sel ? COEF_W'(-m_abs_nxt) : m_abs_nxt;
    mm        = m_abs_r * m_abs_r;
    vd        = $signed({1'b0, q2_r}) - $signed({1'b0, msq_r});
    if (vd[COEF_W+1]) begin
      v_nxt = '0;
    end else if (vd[COEF_W]) begin
      v_nxt = '1;
    end else begin
      v_nxt = vd[COEF_W-1:0];
    end
    if (m_neg_r) begin
      disp_nxt = (div_rsp.quo > DIV_NW'(C_MIN)) ? C_MIN : COEF_W'(-div_rsp.quo);
    end else begin
      disp_nxt = (div_rsp.quo > DIV_NW'(C_MAX)) ? C_MAX : div_rsp.quo[COEF_W-1:0];
    end
  end

  // divider requests
  always_comb begin
    stats_go         = (state_r == S_DISP_GO) && (m_abs_r != '0);
    div_req.start    = (state_r == S_MEAN_GO) || (state_r == S_SQ_GO) || stats_go;
    div_req.divisor  = (state_r == S_DISP_GO) ? m_abs_r : DIV_DW'(n_r);
    unique case (state_r)
      S_MEAN_GO: div_req.dividend = DIV_NW'(sabs);
      S_SQ_GO:   div_req.dividend = DIV_NW'(comp_r ? sq_im_r : sq_re_r);
      default:   div_req.dividend = DIV_NW'({v_r, {DISP_SH{1'b0}}});
    endcase
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer with its datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      coef_re_r   <= '0;
      coef_im_r   <= '0;
      sum_re_r    <= '0;
      sum_im_r    <= '0;
      sq_re_r     <= '0;
      sq_im_r     <= '0;
      n_r         <= '0;
      comp_r      <= 1'b0;
    end else begin
      // drop the output word once taken, unless a new one is loaded now
      if (out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= S_PROD;
          end
        end
        S_PROD: begin
          z_re_r  <= z_re_nxt;
          z_im_r  <= z_im_nxt;
          state_r <= S_SQR;
        end
        S_SQR: begin
          rr_r    <= r_re * r_re;
          qq_r    <= r_im * r_im;
          rq_r    <= r_re * r_im;
          state_r <= S_MU;
        end
        S_MU: begin
          d_re_r  <= D_W'(mp_re >>> 16);
          d_im_r  <= D_W'(mp_im >>> 16);
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (cfg.train) begin
            coef_re_r <= w_re_nxt;
            coef_im_r <= w_im_nxt;
          end
          state_r <= S_ABS2;
        end
        S_ABS2: begin
          t_re_r  <= sqa[2*COEF_W-1:FRAC_W];
          t_im_r  <= sqi[2*COEF_W-1:FRAC_W];
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_re_r <= sum_re_r + SUM_W'(coef_re_r);
          sum_im_r <= sum_im_r + SUM_W'(coef_im_r);
          sq_re_r  <= sq_re_r + SQS_W'(t_re_r);
          sq_im_r  <= sq_im_r + SQS_W'(t_im_r);
          n_r      <= n_r + 1'b1;
          comp_r   <= 1'b0;
          state_r  <= item_r.last ? S_MEAN_GO : S_EMIT;
        end
        S_MEAN_GO: state_r <= S_MEAN_W;
        S_MEAN_W: begin
          if (div_rsp.done) begin
            m_abs_r             <= m_abs_nxt;
            m_neg_r             <= neg_sel;
            st_r[comp_r].mean   <= mean_nxt;
            state_r             <= S_SQ_GO;
          end
        end
        S_SQ_GO: state_r <= S_SQ_W;
        S_SQ_W: begin
          if (div_rsp.done) begin
            q2_r    <= (COEF_W + 1)'(div_rsp.quo);
            state_r <= S_MSQ;
          end
        end
        S_MSQ: begin
          msq_r   <= (COEF_W + 1)'(mm >> FRAC_W);
          state_r <= S_VAR;
        end
        S_VAR: begin
          v_r                  <= v_nxt;
          st_r[comp_r].var_v   <= v_nxt;
          state_r              <= S_DISP_GO;
        end
        S_DISP_GO: begin
          if (m_abs_r == '0) begin
            st_r[comp_r].disp <= C_MAX;
            comp_r            <= 1'b1;
            state_r           <= comp_r ? S_EMIT : S_MEAN_GO;
          end else begin
            state_r <= S_DISP_W;
          end
        end
        S_DISP_W: begin
          if (div_rsp.done) begin
            st_r[comp_r].disp <= disp_nxt;
            comp_r            <= 1'b1;
            state_r           <= comp_r ? S_EMIT : S_MEAN_GO;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.out_i       <= sat_s(z_re_r);
            out_data_r.out_q       <= sat_s(z_im_r);
            out_data_r.coef_re     <= coef_re_r;
            out_data_r.coef_im     <= coef_im_r;
            out_data_r.mean_re     <= item_r.last ? st_r[0].mean : '0;
            out_data_r.mean_im     <= item_r.last ? st_r[1].mean : '0;
            out_data_r.var_re      <= item_r.last ? st_r[0].var_v : '0;
            out_data_r.var_im      <= item_r.last ? st_r[1].var_v : '0;
            out_data_r.disp_re     <= item_r.last ? st_r[0].disp : '0;
            out_data_r.disp_im     <= item_r.last ? st_r[1].disp : '0;
            out_data_r.stats_valid <= item_r.last;
            // reload coefficient and clear the block sums
            if (item_r.last) begin
              coef_re_r <= cfg.start_re;
              coef_im_r <= cfg.start_im;
              sum_re_r  <= '0;
              sum_im_r  <= '0;
              sq_re_r   <= '0;
              sq_im_r   <= '0;
              n_r       <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/iq_balance_lms_trainer_core.sv -----
// I/Q balance corrector with LMS coefficient training: top level and register file.
//
// Each input word (one complex Q1.15 sample) yields one output word carrying the
// corrected sample z = s + w*conj(s) and the coefficient after the LMS update.
// The last word of a block, flagged by block_end or reached after 65536 samples,
// also carries the block mean, variance and dispersion of w, after which w is
// reloaded from start_coef_re / start_coef_im. A two-word queue sits in front of
// the arithmetic and an output register behind it, so either side may stall.
// An ordinary sample passes the multiply chain of the update in order (product,
// squares, step scaling, update, square for the sums, accumulate).
// A block-end sample also runs the shared 50-step serial divider up to six times
// (mean, mean square and, for a nonzero mean, dispersion for each component).
// Registers at byte addresses 0x0 step_size, 0x4 start_coef_re, 0x8 start_coef_im,
// 0xC train_enable; write them only while the block is idle.
module iq_balance_lms_trainer_core import iqbal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    REG_STEP     = 2'd0,
    REG_START_RE = 2'd1,
    REG_START_IM = 2'd2,
    REG_TRAIN    = 2'd3
  } reg_idx_t;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;
  item_t    q_item;
  logic     q_valid;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step     <= STEP_W'(256);
      cfg_r.start_re <= '0;
      cfg_r.start_im <= '0;
      cfg_r.train    <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_STEP:     cfg_r.step     <= pwdata[STEP_W-1:0];
        REG_START_RE: cfg_r.start_re <= pwdata;
        REG_START_IM: cfg_r.start_im <= pwdata;
        REG_TRAIN:    cfg_r.train    <= pwdata[0];
        default:      cfg_r.train    <= cfg_r.train;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (idx)
      REG_STEP:     prdata = 32'(cfg_r.step);
      REG_START_RE: prdata = cfg_r.start_re;
      REG_START_IM: prdata = cfg_r.start_im;
      REG_TRAIN:    prdata = 32'(cfg_r.train);
      default:      prdata = '0;
    endcase
  end

  iqbal_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  iqbal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  iqbal_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // divider is never restarted mid-run
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");

  // back end only takes queued words
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // mean_re, var_im and disp_re are zero on ordinary words
  a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.stats_valid) |->
      (out_data.mean_re == '0 && out_data.var_im == '0 && out_data.disp_re == '0))
    else $error("statistics on a non block-end word");

endmodule

// ----- sim/tb_iq_balance_lms_trainer_core.sv -----
// Testbench of the I/Q balance LMS trainer: random samples and blocks, scoreboard check.
`timescale 1ns / 100ps

// Predicts each output word and checks the words that come back.
class iqbal_scoreboard;
  logic [15:0] step_size;
  logic signed [31:0] start_re, start_im;
  logic train;
  logic signed [63:0] w_re, w_im, sum_re, sum_im;
  logic [63:0] sq_re, sq_im;
  int unsigned count;
  iqbal_pkg::out_t pending[$];
  int errors;

  function new();
    step_size = 16'd256;
    start_re = 0;
    start_im = 0;
    train = 1;
    errors = 0;
    reload();
  endfunction

  function void reload();
    w_re = start_re;
    w_im = start_im;
    sum_re = 0;
    sum_im = 0;
    sq_re = 0;
    sq_im = 0;
    count = 0;
  endfunction

  function void set_reg(int idx, logic [31:0] val);
    case (idx)
      0: step_size = val[15:0];
      1: start_re = val;
      2: start_im = val;
      3: train = val[0];
      default: ;
    endcase
  endfunction

  // Saturate to the signed 32-bit range.
  function logic signed [63:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function logic signed [63:0] floor_div(logic signed [63:0] v, logic signed [63:0] n);
    logic signed [63:0] q;
    q = v / n;
    if ((v % n) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  // Mean, variance and dispersion of one coefficient component.
  function void block_stats(logic signed [63:0] s, logic [63:0] sq, int unsigned n,
                            output logic [31:0] m32, output logic [31:0] v32,
                            output logic [31:0] d32);
    logic signed [63:0] m, am, v, d;
    m = floor_div(s, n);
    am = (m < 0) ? -m : m;
    v = $signed(sq / n) - $signed((am * am) >> 30);
    if (v < 0) v = 0;
    if (v > 64'sd4294967295) v = 64'sd4294967295;
    if (m == 0) d = 64'sd2147483647;
    else d = sat32((v * 65536) / m);
    m32 = m[31:0];
    v32 = v[31:0];
    d32 = d[31:0];
  endfunction

  function void note_sample(iqbal_pkg::in_t s);
    iqbal_pkg::out_t r;
    logic signed [63:0] si, sq, zr, zi, mu, dr, di, ar, ai;
    logic last;
    si = s.sample_i;
    sq = s.sample_q;
    last = s.block_end;
    zr = si + ((w_re * si + w_im * sq) >>> 30);
    zi = sq + ((w_im * si - w_re * sq) >>> 30);
    r = '0;
    r.out_i = sat16(zr);
    r.out_q = sat16(zi);
    if (train) begin
      mu = {48'd0, step_size};
      dr = (mu * (zr * zr - zi * zi)) >>> 16;
      di = (mu * (2 * zr * zi)) >>> 16;
      w_re = sat32(w_re - dr);
      w_im = sat32(w_im - di);
    end
    r.coef_re = w_re[31:0];
    r.coef_im = w_im[31:0];
    ar = (w_re < 0) ? -w_re : w_re;
    ai = (w_im < 0) ? -w_im : w_im;
    sum_re += w_re;
    sum_im += w_im;
    sq_re += (ar * ar) >> 30;
    sq_im += (ai * ai) >> 30;
    count++;
    if (count >= iqbal_pkg::MAX_BLOCK) last = 1;
    if (last) begin
      block_stats(sum_re, sq_re, count, r.mean_re, r.var_re, r.disp_re);
      block_stats(sum_im, sq_im, count, r.mean_im, r.var_im, r.disp_im);
      r.stats_valid = 1;
      reload();
    end
    pending.push_back(r);
  endfunction

  function void check_word(iqbal_pkg::out_t a);
    iqbal_pkg::out_t e;
    if (pending.size() == 0) begin
      $error("unexpected output word %h", a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.out_i !== e.out_i) begin
      $error("out_i exp %0d got %0d", e.out_i, a.out_i); errors++;
    end
    if (a.out_q !== e.out_q) begin
      $error("out_q exp %0d got %0d", e.out_q, a.out_q); errors++;
    end
    if (a.coef_re !== e.coef_re) begin
      $error("coef_re exp %0d got %0d", e.coef_re, a.coef_re); errors++;
    end
    if (a.coef_im !== e.coef_im) begin
      $error("coef_im exp %0d got %0d", e.coef_im, a.coef_im); errors++;
    end
    if (a.mean_re !== e.mean_re) begin
      $error("mean_re exp %0d got %0d", e.mean_re, a.mean_re); errors++;
    end
    if (a.mean_im !== e.mean_im) begin
      $error("mean_im exp %0d got %0d", e.mean_im, a.mean_im); errors++;
    end
    if (a.var_re !== e.var_re) begin
      $error("var_re exp %0d got %0d", e.var_re, a.var_re); errors++;
    end
    if (a.var_im !== e.var_im) begin
      $error("var_im exp %0d got %0d", e.var_im, a.var_im); errors++;
    end
    if (a.disp_re !== e.disp_re) begin
      $error("disp_re exp %0d got %0d", e.disp_re, a.disp_re); errors++;
    end
    if (a.disp_im !== e.disp_im) begin
      $error("disp_im exp %0d got %0d", e.disp_im, a.disp_im); errors++;
    end
    if (a.stats_valid !== e.stats_valid) begin
      $error("stats_valid exp %0d got %0d", e.stats_valid, a.stats_valid); errors++;
    end
  endfunction
endclass

module tb_iq_balance_lms_trainer_core;
  import iqbal_pkg::*;

  localparam int REG_STEP     = 0;
  localparam int REG_START_RE = 1;
  localparam int REG_START_IM = 2;
  localparam int REG_TRAIN    = 3;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic stim_done = 0;

  iqbal_scoreboard sb = new();

  iq_balance_lms_trainer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Mostly short gaps, now and then a long one.
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic reg_write(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  // Hold the word until accepted; valid stays high across back-to-back words.
  task automatic send_sample(logic signed [15:0] i, logic signed [15:0] q, logic last,
                             bit allow_gap);
    int g;
    in_t w;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    w.sample_i = i;
    w.sample_q = q;
    w.block_end = last;
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(w);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random small samples keep the training loop stable; some full-scale ones.
  task automatic random_block(int len);
    logic signed [15:0] i, q;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        i = 16'($urandom);
        q = 16'($urandom);
      end else begin
        i = 16'($signed($urandom_range(0, 8191)) - 4096);
        q = 16'($signed($urandom_range(0, 8191)) - 4096);
      end
      send_sample(i, q, k == len - 1, 1);
    end
  endtask

  // Drain output words with random stalls.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      g = gap_len();
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, block end, mean zero, reset settings
    send_sample(16'sh7fff, 16'sh7fff, 0, 0);
    send_sample(16'sh8000, 16'sh8000, 0, 0);
    send_sample(16'sh7fff, 16'sh8000, 0, 0);
    send_sample(16'sh0000, 16'sh0000, 1, 0);
    send_sample(16'sh0000, 16'sh0000, 1, 0);
    send_sample(16'sh5555, 16'shaaaa, 0, 1);
    send_sample(16'shaaaa, 16'sh5555, 1, 1);
    drain();

    // apply mode with extreme start coefficients
    reg_write(REG_TRAIN, 0);
    reg_write(REG_START_RE, 32'h7fffffff);
    reg_write(REG_START_IM, 32'h80000000);
    send_sample(16'sh7fff, 16'sh8000, 0, 0);
    send_sample(16'sh8000, 16'sh7fff, 0, 0);
    send_sample(16'sh1234, 16'shedcb, 1, 0);
    drain();
    reg_write(REG_START_RE, 32'h80000000);
    reg_write(REG_START_IM, 32'h7fffffff);
    send_sample(16'sh7fff, 16'sh7fff, 0, 0);
    send_sample(16'sh8000, 16'sh0001, 1, 0);
    drain();

    // training with extreme steps saturates the coefficient
    reg_write(REG_TRAIN, 1);
    reg_write(REG_STEP, 32'h0000ffff);
    reg_write(REG_START_RE, 32'h00000000);
    reg_write(REG_START_IM, 32'h00000000);
    send_sample(16'sh7fff, 16'sh0000, 0, 0);
    send_sample(16'sh0000, 16'sh7fff, 0, 0);
    send_sample(16'sh4000, 16'sh4000, 1, 0);
    drain();
    reg_write(REG_STEP, 32'h00000000);
    random_block(4);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 10; ph++) begin
      reg_write(REG_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2048));
      reg_write(REG_START_RE, $urandom_range(0, 3) == 0 ? $urandom
                : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
      reg_write(REG_START_IM, $urandom_range(0, 3) == 0 ? $urandom
                : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
      reg_write(REG_TRAIN, 32'($urandom_range(0, 3) != 0));
      for (int b = 0; b < 4; b++) random_block($urandom_range(1, 18));
      drain();
    end

    stim_done = 1;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_iq_balance_lms_trainer_core: done, clean");
    end else begin
      $display("tb_iq_balance_lms_trainer_core: done, errors");
    end
    $finish;
  end

  // Hold-off on a hang.
  initial begin
    #4000000;
    $display("tb_iq_balance_lms_trainer_core: done, errors");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/iqbal_pkg.sv
hdl/iqbal_div.sv
hdl/iqbal_front.sv
hdl/iqbal_back.sv
hdl/iq_balance_lms_trainer_core.sv
sim/tb_iq_balance_lms_trainer_core.sv
